>>> rtl/aos_fce_pkg.sv
// shared types, register codes and reset constants for the aos frame checker
package aos_fce_pkg;

  // frame size limits
  localparam int unsigned FRAME_BYTES_MAX_DEF = 4096;
  localparam int unsigned FRAME_BYTES_MIN     = 9;

  // register widths
  localparam int unsigned FLEN_W = 13;
  localparam int unsigned SYNC_W = 32;
  localparam int unsigned POFF_W = 12;
  localparam int unsigned PLEN_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 24;
  localparam int unsigned TOTAL_W = 32;

  // register reset values
  localparam logic [FLEN_W-1:0] FRAME_LENGTH_RST   = 13'd1024;
  localparam logic [SYNC_W-1:0] SYNC_WORD_RST      = 32'h1ACF_FC1D;
  localparam logic [POFF_W-1:0] PAYLOAD_OFFSET_RST = 12'd44;
  localparam logic [PLEN_W-1:0] PAYLOAD_LENGTH_RST = 13'd850;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 104;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_LENGTH   = 2'd0,
    CFG_SYNC_WORD      = 2'd1,
    CFG_PAYLOAD_OFFSET = 2'd2,
    CFG_PAYLOAD_LENGTH = 2'd3
  } cfg_idx_e;

  // register set seen by the frame logic
  typedef struct packed {
    logic [FLEN_W-1:0] frame_length;
    logic [SYNC_W-1:0] sync_word;
    logic [POFF_W-1:0] payload_offset;
    logic [PLEN_W-1:0] payload_length;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic                payload_valid;
    logic [BYTE_W-1:0]   payload_byte;
    logic                payload_last;
    logic                frame_done;
    logic                sync_error;
    logic                discontinuity;
    logic [COUNT_W-1:0]  frame_count;
    logic [TOTAL_W-1:0]  discontinuity_total;
    logic [TOTAL_W-1:0]  frames_total;
  } res_t;

endpackage

>>> rtl/aos_fce_cfg_regs.sv
// configuration register file of the aos frame checker
module aos_fce_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [aos_fce_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [aos_fce_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output aos_fce_pkg::cfg_t                     cfg_o
);

  aos_fce_pkg::cfg_t cfg_q;

  // register writes, decoded by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_length   <= aos_fce_pkg::FRAME_LENGTH_RST;
      cfg_q.sync_word      <= aos_fce_pkg::SYNC_WORD_RST;
      cfg_q.payload_offset <= aos_fce_pkg::PAYLOAD_OFFSET_RST;
      cfg_q.payload_length <= aos_fce_pkg::PAYLOAD_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (aos_fce_pkg::cfg_idx_e'(cfg_addr_i))
        aos_fce_pkg::CFG_FRAME_LENGTH: begin
          cfg_q.frame_length <= cfg_wdata_i[aos_fce_pkg::FLEN_W-1:0];
        end
        aos_fce_pkg::CFG_SYNC_WORD: begin
          cfg_q.sync_word <= cfg_wdata_i[aos_fce_pkg::SYNC_W-1:0];
        end
        aos_fce_pkg::CFG_PAYLOAD_OFFSET: begin
          cfg_q.payload_offset <= cfg_wdata_i[aos_fce_pkg::POFF_W-1:0];
        end
        aos_fce_pkg::CFG_PAYLOAD_LENGTH: begin
          cfg_q.payload_length <= cfg_wdata_i[aos_fce_pkg::PLEN_W-1:0];
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/aos_fce_frame_proc.sv
// frame position tracking, header checks, payload window and status totals
module aos_fce_frame_proc #(
  parameter int unsigned MAX_FRAME_BYTES = aos_fce_pkg::FRAME_BYTES_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  aos_fce_pkg::cfg_t                 cfg_i,
  input  logic                              step_i,
  input  logic [aos_fce_pkg::BYTE_W-1:0]    byte_i,
  input  logic                              start_i,
  output logic                              res_valid_o,
  output aos_fce_pkg::res_t                 res_o
);

  // compare width covers the clamped length and offset plus length
  localparam int unsigned LEN_BITS = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CW = (LEN_BITS > 14) ? LEN_BITS : 14;
  localparam int unsigned PW = $clog2(MAX_FRAME_BYTES);

  localparam logic [CW-1:0] FlenMax = CW'(MAX_FRAME_BYTES);
  localparam logic [CW-1:0] FlenMin = CW'(aos_fce_pkg::FRAME_BYTES_MIN);
  localparam logic [aos_fce_pkg::TOTAL_W-1:0] TotalMax = '1;

  logic [PW-1:0]                      byte_pos_q, byte_pos_d;
  logic [31:0]                        header_q, header_d;
  logic [aos_fce_pkg::COUNT_W-1:0]    cur_count_q, cur_count_d;
  logic [aos_fce_pkg::COUNT_W-1:0]    prev_count_q, prev_count_d;
  logic                               first_frame_q, first_frame_d;
  logic [aos_fce_pkg::TOTAL_W-1:0]    disc_total_q, disc_total_d;
  logic [aos_fce_pkg::TOTAL_W-1:0]    frame_total_q, frame_total_d;

  logic [CW-1:0]                      flen_raw, flen, pos, wend_raw, wend, poff;
  logic                               first_frame_w, pvalid, plast, done, serr, disc;
  logic [aos_fce_pkg::TOTAL_W-1:0]    disc_base;
  logic [aos_fce_pkg::COUNT_W-1:0]    expect_count;

  // clamp frame length and find this byte's position
  always_comb begin
    flen_raw = CW'(cfg_i.frame_length);
    if (flen_raw < FlenMin) begin
      flen = FlenMin;
    end else if (flen_raw > FlenMax) begin
      flen = FlenMax;
    end else begin
      flen = flen_raw;
    end
    pos = start_i ? '0 : CW'(byte_pos_q);
    if (pos >= flen) begin
      pos = '0;
    end
    first_frame_w = start_i | first_frame_q;
    disc_base     = start_i ? '0 : disc_total_q;
  end

  // header capture: sync word and frame count bytes
  always_comb begin
    header_d    = header_q;
    cur_count_d = cur_count_q;
    if (pos < CW'(4)) begin
      header_d = {header_q[23:0], byte_i};
    end else if (pos >= CW'(6) && pos <= CW'(8)) begin
      cur_count_d = {cur_count_q[aos_fce_pkg::COUNT_W-9:0], byte_i};
    end
  end

  // payload window clipped to the frame
  always_comb begin
    poff     = CW'(cfg_i.payload_offset);
    wend_raw = poff + CW'(cfg_i.payload_length);
    wend     = (wend_raw > flen) ? flen : wend_raw;
    pvalid   = (pos >= poff) && (pos < wend);
    plast    = pvalid && (pos == wend - CW'(1));
    done     = (pos == flen - CW'(1));
  end

  // frame end checks and saturating totals
  always_comb begin
    expect_count  = prev_count_q + aos_fce_pkg::COUNT_W'(1);
    serr          = (header_d != cfg_i.sync_word);
    disc          = !first_frame_w && (cur_count_d != expect_count) && (cur_count_d != '0);
    disc_total_d  = disc_base;
    frame_total_d = frame_total_q;
    prev_count_d  = prev_count_q;
    first_frame_d = first_frame_w;
    byte_pos_d    = PW'(pos + CW'(1));
    if (done) begin
      if (disc && disc_base != TotalMax) begin
        disc_total_d = disc_base + aos_fce_pkg::TOTAL_W'(1);
      end
      if (frame_total_q != TotalMax) begin
        frame_total_d = frame_total_q + aos_fce_pkg::TOTAL_W'(1);
      end
      prev_count_d  = cur_count_d;
      first_frame_d = 1'b0;
      byte_pos_d    = '0;
    end
  end

  // result item
  always_comb begin
    res_o                     = '0;
    res_o.payload_valid       = pvalid;
    res_o.payload_byte        = pvalid ? byte_i : '0;
    res_o.payload_last        = plast;
    if (done) begin
      res_o.frame_done          = 1'b1;
      res_o.sync_error          = serr;
      res_o.discontinuity       = disc;
      res_o.frame_count         = cur_count_d;
      res_o.discontinuity_total = disc_total_d;
      res_o.frames_total        = frame_total_d;
    end
    res_valid_o = pvalid | done;
  end

  // state update, one item per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q    <= '0;
      header_q      <= '0;
      cur_count_q   <= '0;
      prev_count_q  <= '0;
      first_frame_q <= 1'b1;
      disc_total_q  <= '0;
      frame_total_q <= '0;
    end else if (step_i) begin
      byte_pos_q    <= byte_pos_d;
      header_q      <= header_d;
      cur_count_q   <= cur_count_d;
      prev_count_q  <= prev_count_d;
      first_frame_q <= first_frame_d;
      disc_total_q  <= disc_total_d;
      frame_total_q <= frame_total_d;
    end
  end

endmodule

>>> rtl/aos_frame_check_extract_core.sv
// top level of the aos frame sync and count checker with payload extraction
//
//  channel   direction  fields
//  s_axis    in         tdata: byte_in; tuser: batch_start
//  m_axis    out        tdata: status and payload fields; tlast: payload_last
//  cfg       in         frame_length, sync_word, payload_offset, payload_length
//
// one item per cycle sustained while m_axis does not stall; an accepted item passes
// from the input register through the frame state update into the result register
// bytes that yield no payload and no frame end leave no result item
// reset clears position, counts and totals; configuration returns to defaults
// a stall on m_axis holds the result register and backs up into the input register
module aos_frame_check_extract_core #(
  parameter int unsigned MAX_FRAME_BYTES = aos_fce_pkg::FRAME_BYTES_MAX_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // configuration write port
  input  logic                                     cfg_we_i,
  input  logic [aos_fce_pkg::CFG_IDX_W-1:0]        cfg_addr_i,
  input  logic [aos_fce_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // input stream
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  logic [aos_fce_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [7:0] byte_in
  input  logic                                     s_axis_tuser,  // [0] batch_start
  // output stream
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // [0] payload_valid, [8:1] payload_byte, [9] frame_done, [10] sync_error,
  // [11] discontinuity, [35:12] frame_count, [67:36] discontinuity_total,
  // [99:68] frames_total, [103:100] zero
  output logic [aos_fce_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                     m_axis_tlast   // payload_last
);

  aos_fce_pkg::cfg_t cfg;
  aos_fce_pkg::res_t res, out_res_q;
  logic              res_valid, advance;
  logic              in_valid_q, in_start_q, out_valid_q;
  logic [aos_fce_pkg::BYTE_W-1:0] in_byte_q;

  aos_fce_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // move an item forward when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata[aos_fce_pkg::BYTE_W-1:0];
      in_start_q <= s_axis_tuser;
    end
  end

  aos_fce_frame_proc #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_proc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .start_i     (in_start_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  // pack the result item onto the stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_res_q.payload_last;
  assign m_axis_tdata  = {4'b0000,
                          out_res_q.frames_total,
                          out_res_q.discontinuity_total,
                          out_res_q.frame_count,
                          out_res_q.discontinuity,
                          out_res_q.sync_error,
                          out_res_q.frame_done,
                          out_res_q.payload_byte,
                          out_res_q.payload_valid};

endmodule

>>> bench/testbench.sv
// self-checking bench for the aos frame sync, count check and payload extract core
module testbench;

  localparam int unsigned FRAME_MAX   = aos_fce_pkg::FRAME_BYTES_MAX_DEF;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned RAND_ITEMS  = 590;
  localparam int unsigned SETTLE_CYC  = 8;
  localparam int unsigned MAX_REPORTS = 10;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                cfg_we_i;
  logic [aos_fce_pkg::CFG_IDX_W-1:0]   cfg_addr_i;
  logic [aos_fce_pkg::CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  logic [aos_fce_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] byte_in
  logic                                s_axis_tuser;   // [0] batch_start
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  // [0] payload_valid, [8:1] payload_byte, [9] frame_done, [10] sync_error,
  // [11] discontinuity, [35:12] frame_count, [67:36] discontinuity_total,
  // [99:68] frames_total, [103:100] zero
  logic [aos_fce_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                                m_axis_tlast;   // payload_last

  aos_frame_check_extract_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // register copy kept by the frame model
  logic [aos_fce_pkg::FLEN_W-1:0]  mdl_flen;
  logic [aos_fce_pkg::SYNC_W-1:0]  mdl_sync;
  logic [aos_fce_pkg::POFF_W-1:0]  mdl_poff;
  logic [aos_fce_pkg::PLEN_W-1:0]  mdl_plen;

  // frame tracking state of the model
  logic [11:0]                     mdl_pos;
  logic [31:0]                     mdl_hdr;
  logic [aos_fce_pkg::COUNT_W-1:0] mdl_cnt;
  logic [aos_fce_pkg::COUNT_W-1:0] mdl_prev_cnt;
  logic                            mdl_first;
  logic [aos_fce_pkg::TOTAL_W-1:0] mdl_disc_tot;
  logic [aos_fce_pkg::TOTAL_W-1:0] mdl_frame_tot;

  // payload and status items still owed by the core
  aos_fce_pkg::res_t frame_out_q[$];

  // bench control and bookkeeping
  bit          tx_gaps_on;
  bit          rx_gaps_on;
  int unsigned rx_hold;
  int unsigned err_cnt;
  int unsigned items_sent;
  int unsigned outs_checked;
  int unsigned frames_checked;
  int unsigned payload_checked;
  int unsigned rand_items;
  logic [aos_fce_pkg::COUNT_W-1:0] next_cnt;

  aos_fce_pkg::res_t mon_got;
  aos_fce_pkg::res_t mon_want;
  int unsigned       idle_cycles;

  // effective frame length, clamped to the supported range
  function automatic int unsigned eff_len();
    int unsigned n;
    n = 32'(mdl_flen);
    if (n < aos_fce_pkg::FRAME_BYTES_MIN) n = aos_fce_pkg::FRAME_BYTES_MIN;
    if (n > FRAME_MAX) n = FRAME_MAX;
    return n;
  endfunction

  // model one accepted byte and queue the item it causes, if any
  task automatic model_frame_byte(input logic [7:0] b, input logic start);
    int unsigned flen;
    int unsigned pos;
    int unsigned wend;
    int unsigned poff;
    logic pv;
    logic pl;
    logic dn;
    logic disc;
    logic [aos_fce_pkg::COUNT_W-1:0] succ;
    aos_fce_pkg::res_t r;
    flen = eff_len();
    if (start) begin
      mdl_pos      = '0;
      mdl_disc_tot = '0;
      mdl_first    = 1'b1;
    end
    pos = 32'(mdl_pos);
    if (pos >= flen) pos = 0;
    if (pos < 4) mdl_hdr = {mdl_hdr[23:0], b};
    else if (pos >= 6 && pos <= 8) mdl_cnt = {mdl_cnt[15:0], b};
    // payload window clipped to the frame end
    poff = 32'(mdl_poff);
    wend = poff + 32'(mdl_plen);
    if (wend > flen) wend = flen;
    pv = (pos >= poff) && (pos < wend);
    pl = pv && (pos == wend - 1);
    dn = (pos == flen - 1);
    r = '0;
    r.payload_valid = pv;
    r.payload_byte  = pv ? b : 8'h00;
    r.payload_last  = pl;
    if (dn) begin
      disc = 1'b0;
      succ = mdl_prev_cnt + 24'd1;
      if (!mdl_first) disc = (mdl_cnt != succ) && (mdl_cnt != '0);
      if (disc && mdl_disc_tot != '1) mdl_disc_tot = mdl_disc_tot + 32'd1;
      if (mdl_frame_tot != '1) mdl_frame_tot = mdl_frame_tot + 32'd1;
      r.frame_done          = 1'b1;
      r.sync_error          = (mdl_hdr != mdl_sync);
      r.discontinuity       = disc;
      r.frame_count         = mdl_cnt;
      r.discontinuity_total = mdl_disc_tot;
      r.frames_total        = mdl_frame_tot;
      mdl_prev_cnt = mdl_cnt;
      mdl_first    = 1'b0;
      mdl_pos      = '0;
    end else begin
      mdl_pos = 12'(pos + 1);
    end
    if (pv || dn) frame_out_q.push_back(r);
  endtask

  // idle length: mostly none or short, a few long
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one byte and wait until the core takes it
  task automatic push_frame_byte(input logic [7:0] b, input logic start);
    int unsigned gap;
    gap = pick_gap(tx_gaps_on);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    model_frame_byte(b, start);
    items_sent++;
  endtask

  // send nbytes of a frame with the given marker and count
  task automatic push_frame(input int unsigned nbytes, input logic [31:0] sync,
                            input logic [aos_fce_pkg::COUNT_W-1:0] count,
                            input logic start);
    logic [7:0] b;
    for (int unsigned i = 0; i < nbytes; i++) begin
      if (i < 4) b = sync[(3 - i) * 8 +: 8];
      else if (i >= 6 && i <= 8) b = count[(8 - i) * 8 +: 8];
      else b = 8'($urandom);
      push_frame_byte(b, start && (i == 0));
    end
  endtask

  // stop offering and wait until every owed item is out and the core is quiet
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (frame_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // write all four registers while the core is idle
  task automatic set_config(input logic [aos_fce_pkg::FLEN_W-1:0] flen,
                            input logic [aos_fce_pkg::SYNC_W-1:0] sync,
                            input logic [aos_fce_pkg::POFF_W-1:0] poff,
                            input logic [aos_fce_pkg::PLEN_W-1:0] plen);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= aos_fce_pkg::CFG_FRAME_LENGTH;
    cfg_wdata_i <= aos_fce_pkg::CFG_DATA_W'(flen);
    @(negedge clk_i);
    cfg_addr_i  <= aos_fce_pkg::CFG_SYNC_WORD;
    cfg_wdata_i <= sync;
    @(negedge clk_i);
    cfg_addr_i  <= aos_fce_pkg::CFG_PAYLOAD_OFFSET;
    cfg_wdata_i <= aos_fce_pkg::CFG_DATA_W'(poff);
    @(negedge clk_i);
    cfg_addr_i  <= aos_fce_pkg::CFG_PAYLOAD_LENGTH;
    cfg_wdata_i <= aos_fce_pkg::CFG_DATA_W'(plen);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    mdl_flen = flen;
    mdl_sync = sync;
    mdl_poff = poff;
    mdl_plen = plen;
  endtask

  // start of a frame with the registers left at their reset values
  task automatic test_reset_defaults();
    push_frame(60, mdl_sync, 24'd5, 1'b1);
  endtask

  // count continuity rules on shortest frames, whole frame as payload
  task automatic test_count_rules();
    set_config('0, 32'h0000_0000, '0, '1);
    push_frame(eff_len(), 32'h0000_0000, 24'd0, 1'b1);
    push_frame(eff_len(), 32'h0000_0000, 24'd1, 1'b0);
    push_frame(eff_len(), 32'h0000_0000, 24'd3, 1'b0);
    push_frame(eff_len(), 32'h0000_0000, 24'd0, 1'b0);
    push_frame(eff_len(), 32'h0000_0000, 24'hFF_FFFF, 1'b0);
    // count wrap to zero is accepted
    push_frame(eff_len(), 32'h0000_0000, 24'd0, 1'b0);
    push_frame(eff_len(), 32'hFFFF_FFFF, 24'd1, 1'b0);
  endtask

  // batch start abandons a partial frame and clears the discontinuity total
  task automatic test_batch_restart();
    push_frame(5, mdl_sync, 24'd2, 1'b0);
    push_frame(eff_len(), mdl_sync, 24'd7, 1'b1);
    push_frame(eff_len(), mdl_sync, 24'd9, 1'b0);
  endtask

  // payload window edges: empty, beyond frame, single byte on last, mid frame
  task automatic test_window_edges();
    set_config(13'd9, 32'hFFFF_FFFF, 12'd0, 13'd0);
    push_frame(eff_len(), 32'hFFFF_FFFF, 24'd1, 1'b1);
    set_config(13'd9, 32'hFFFF_FFFF, 12'd4095, 13'd1);
    push_frame(eff_len(), 32'hFFFF_FFFF, 24'd2, 1'b0);
    set_config(13'd9, 32'hFFFF_FFFF, 12'd8, 13'd1);
    push_frame(eff_len(), 32'hFFFF_FFFF, 24'd3, 1'b0);
    set_config(13'd9, 32'hA5A5_5A5A, 12'd3, 13'd2);
    push_frame(eff_len(), 32'hA5A5_5A5A, 24'd4, 1'b0);
  endtask

  // frame length shrinks below the current position mid frame
  task automatic test_shrink_length();
    set_config(13'd40, 32'h1ACF_FC1D, 12'd2, 13'd30);
    push_frame(20, 32'h1ACF_FC1D, 24'd10, 1'b1);
    set_config(13'd12, 32'h1ACF_FC1D, 12'd2, 13'd30);
    push_frame(eff_len(), 32'h1ACF_FC1D, 24'd11, 1'b0);
    push_frame(eff_len(), 32'h1ACF_FC1D, 24'd12, 1'b0);
  endtask

  // oversize length register clamps to the largest frame; start of one frame
  task automatic test_max_length();
    set_config('1, 32'hFFFF_FFFF, 12'd0, '1);
    tx_gaps_on = 1'b0;
    push_frame(60, 32'hFFFF_FFFF, 24'h80_0000, 1'b1);
    tx_gaps_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, then a full drain
  task automatic test_backpressure();
    set_config(13'd20, 32'h0F0F_F0F0, 12'd0, 13'd20);
    tx_gaps_on = 1'b0;
    rx_hold = 150;
    push_frame(eff_len(), mdl_sync, 24'd100, 1'b1);
    push_frame(eff_len(), mdl_sync, 24'd101, 1'b0);
    push_frame(eff_len(), mdl_sync, 24'd102, 1'b0);
    settle();
    tx_gaps_on = 1'b1;
    push_frame(eff_len(), mdl_sync, 24'd103, 1'b0);
  endtask

  // random settings, mostly well-formed frames with some broken ones and noise
  task automatic test_random();
    int unsigned r;
    int unsigned nfr;
    int unsigned flen;
    int unsigned base;
    int unsigned n;
    logic [aos_fce_pkg::FLEN_W-1:0] c_flen;
    logic [aos_fce_pkg::SYNC_W-1:0] c_sync;
    logic [aos_fce_pkg::POFF_W-1:0] c_poff;
    logic [aos_fce_pkg::PLEN_W-1:0] c_plen;
    logic force_start;
    logic [aos_fce_pkg::COUNT_W-1:0] cnt;
    next_cnt = 24'($urandom);
    while (rand_items < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      c_flen = (r < 10) ? aos_fce_pkg::FLEN_W'($urandom_range(0, 8)) :
               aos_fce_pkg::FLEN_W'($urandom_range(9, 48));
      r = $urandom_range(0, 99);
      c_sync = (r < 10) ? 32'h0 : (r < 20) ? 32'hFFFF_FFFF : 32'($urandom);
      r = $urandom_range(0, 99);
      c_poff = (r < 8) ? aos_fce_pkg::POFF_W'($urandom_range(0, 4095)) :
               aos_fce_pkg::POFF_W'($urandom_range(0, 30));
      r = $urandom_range(0, 99);
      c_plen = (r < 10) ? '0 : (r < 25) ? aos_fce_pkg::PLEN_W'($urandom_range(0, 8191)) :
               aos_fce_pkg::PLEN_W'($urandom_range(1, 40));
      set_config(c_flen, c_sync, c_poff, c_plen);
      tx_gaps_on = ($urandom_range(0, 4) != 0);
      rx_gaps_on = ($urandom_range(0, 4) != 0);
      flen = eff_len();
      force_start = ($urandom_range(0, 3) != 0);
      nfr = $urandom_range(2, 6);
      for (int unsigned f = 0; f < nfr && rand_items < RAND_ITEMS; f++) begin
        base = items_sent;
        r = $urandom_range(0, 99);
        if (r < 60) begin
          push_frame(flen, mdl_sync, next_cnt, force_start);
          next_cnt = next_cnt + 24'd1;
        end else if (r < 70) begin
          push_frame(flen, mdl_sync ^ (32'h1 << $urandom_range(0, 31)), next_cnt,
                     force_start);
          next_cnt = next_cnt + 24'd1;
        end else if (r < 78) begin
          push_frame(flen, mdl_sync, '0, force_start);
          next_cnt = 24'd1;
        end else if (r < 86) begin
          cnt = 24'($urandom);
          push_frame(flen, mdl_sync, cnt, force_start);
          next_cnt = cnt + 24'd1;
        end else if (r < 90) begin
          push_frame(flen, mdl_sync, 24'hFF_FFFF, force_start);
          next_cnt = '0;
        end else if (r < 95) begin
          // truncated frame, the next one starts a new batch
          push_frame($urandom_range(1, flen - 1), mdl_sync, next_cnt, force_start);
        end else begin
          // noise bytes with an occasional batch start
          n = $urandom_range(1, 10);
          repeat (n) push_frame_byte(8'($urandom), ($urandom_range(0, 3) == 0));
        end
        force_start = (r >= 90) ? 1'b1 : ($urandom_range(0, 9) == 0);
        rand_items += items_sent - base;
      end
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // receiver side: forced hold-off first, then random stalls
  initial begin
    int unsigned stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 7) == 0) stall = pick_gap(rx_gaps_on);
      end
    end
  end

  // compare each output item with the oldest owed one
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      mon_got.payload_valid       = m_axis_tdata[0];
      mon_got.payload_byte        = m_axis_tdata[8:1];
      mon_got.payload_last        = m_axis_tlast;
      mon_got.frame_done          = m_axis_tdata[9];
      mon_got.sync_error          = m_axis_tdata[10];
      mon_got.discontinuity       = m_axis_tdata[11];
      mon_got.frame_count         = m_axis_tdata[35:12];
      mon_got.discontinuity_total = m_axis_tdata[67:36];
      mon_got.frames_total        = m_axis_tdata[99:68];
      outs_checked++;
      if (frame_out_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("unexpected output item: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
      end else begin
        mon_want = frame_out_q.pop_front();
        if (mon_got.payload_valid !== mon_want.payload_valid ||
            mon_got.payload_byte !== mon_want.payload_byte ||
            mon_got.payload_last !== mon_want.payload_last ||
            mon_got.frame_done !== mon_want.frame_done ||
            mon_got.sync_error !== mon_want.sync_error ||
            mon_got.discontinuity !== mon_want.discontinuity ||
            mon_got.frame_count !== mon_want.frame_count ||
            mon_got.discontinuity_total !== mon_want.discontinuity_total ||
            mon_got.frames_total !== mon_want.frames_total ||
            m_axis_tdata[103:100] !== 4'h0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("mismatch exp: pv=%b byte=%h pl=%b fd=%b se=%b dc=%b cnt=%h dt=%0d ft=%0d",
                     mon_want.payload_valid, mon_want.payload_byte, mon_want.payload_last,
                     mon_want.frame_done, mon_want.sync_error, mon_want.discontinuity,
                     mon_want.frame_count, mon_want.discontinuity_total,
                     mon_want.frames_total);
            $display("         got: pv=%b byte=%h pl=%b fd=%b se=%b dc=%b cnt=%h ",
                     mon_got.payload_valid, mon_got.payload_byte, mon_got.payload_last,
                     mon_got.frame_done, mon_got.sync_error, mon_got.discontinuity,
                     mon_got.frame_count, "dt=%0d ft=%0d pad=%h",
                     mon_got.discontinuity_total, mon_got.frames_total,
                     m_axis_tdata[103:100]);
          end
        end
        if (mon_want.frame_done) frames_checked++;
        if (mon_want.payload_valid) payload_checked++;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else if (rst_ni) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d still owed",
                 idle_cycles, frame_out_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = aos_fce_pkg::CFG_FRAME_LENGTH;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    tx_gaps_on    = 1'b1;
    rx_gaps_on    = 1'b1;
    rx_hold       = 0;
    err_cnt       = 0;
    items_sent    = 0;
    outs_checked  = 0;
    frames_checked  = 0;
    payload_checked = 0;
    rand_items    = 0;
    idle_cycles   = 0;
    next_cnt      = '0;
    mdl_flen      = aos_fce_pkg::FRAME_LENGTH_RST;
    mdl_sync      = aos_fce_pkg::SYNC_WORD_RST;
    mdl_poff      = aos_fce_pkg::PAYLOAD_OFFSET_RST;
    mdl_plen      = aos_fce_pkg::PAYLOAD_LENGTH_RST;
    mdl_pos       = '0;
    mdl_hdr       = '0;
    mdl_cnt       = '0;
    mdl_prev_cnt  = '0;
    mdl_first     = 1'b1;
    mdl_disc_tot  = '0;
    mdl_frame_tot = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_count_rules();
    test_batch_restart();
    test_window_edges();
    test_shrink_length();
    test_max_length();
    test_backpressure();
    test_random();
    settle();

    if (frame_out_q.size() != 0) err_cnt += frame_out_q.size();
    $display("sent %0d bytes (%0d random), checked %0d output items", items_sent, rand_items,
             outs_checked);
    $display("covered %0d frame statuses and %0d payload bytes, %0d errors", frames_checked,
             payload_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/aos_fce_pkg.sv
rtl/aos_fce_cfg_regs.sv
rtl/aos_fce_frame_proc.sv
rtl/aos_frame_check_extract_core.sv
bench/testbench.sv
